[hw/rtl/lcdns_pkg.sv]
// shared types, constants and helpers for the character lcd nibble sequencer
package lcdns_pkg;

    localparam int PC_W = 5;

    // program entry points in the microcode table
    localparam logic [PC_W-1:0] INIT_ENTRY = 5'd0;
    localparam logic [PC_W-1:0] BYTE_ENTRY = 5'd25;

    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] CMD_HOME    = 8'h02;
    localparam logic [7:0] CMD_DDRAM   = 8'h80;
    localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};
    localparam logic [2:0] ROW_MAX     = 3'd3;

    typedef enum logic [1:0] {
        MODE_INIT = 2'd0,
        MODE_CMD  = 2'd1,
        MODE_DATA = 2'd2,
        MODE_GOTO = 2'd3
    } t_mode;

    typedef enum logic {
        RS_ZERO = 1'b0,
        RS_REG  = 1'b1
    } t_rs_sel;

    typedef enum logic [1:0] {
        NS_CONST = 2'd0,
        NS_HI    = 2'd1,
        NS_LO    = 2'd2
    } t_nib_sel;

    typedef enum logic [3:0] {
        H_1     = 4'd0,
        H_100   = 4'd1,
        H_150   = 4'd2,
        H_250   = 4'd3,
        H_2100  = 4'd4,
        H_2150  = 4'd5,
        H_5100  = 4'd6,
        H_20000 = 4'd7,
        H_TAIL  = 4'd8
    } t_hold;

    // one microcode control word
    typedef struct packed {
        logic     last;
        t_rs_sel  rs_sel;
        logic     en;
        t_nib_sel nib_sel;
        logic [3:0] nib;
        t_hold    hold;
    } t_uword;

    // pin phase produced by the datapath
    typedef struct packed {
        logic        rs;
        logic        en;
        logic [3:0]  nibble;
        logic [14:0] hold_us;
        logic        last;
    } t_phase;

    function automatic logic [14:0] hold_value(t_hold h, logic long_tail);
        logic [14:0] v;
        unique case (h)
            H_1:     v = 15'd1;
            H_100:   v = 15'd100;
            H_150:   v = 15'd150;
            H_250:   v = 15'd250;
            H_2100:  v = 15'd2100;
            H_2150:  v = 15'd2150;
            H_5100:  v = 15'd5100;
            H_20000: v = 15'd20000;
            H_TAIL:  v = long_tail ? 15'd2100 : 15'd150;
            default: v = 15'd1;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/lcdns_ucode_rom.sv]
// microcode table: one control word per program step
module lcdns_ucode_rom (
    input  logic [lcdns_pkg::PC_W-1:0] i_addr,
    output lcdns_pkg::t_uword          o_uword
);
    import lcdns_pkg::*;

    function automatic t_uword mk(logic last, t_rs_sel rs_sel, logic en,
                                  t_nib_sel nsel, logic [3:0] nib, t_hold h);
        t_uword w;
        w.last    = last;
        w.rs_sel  = rs_sel;
        w.en      = en;
        w.nib_sel = nsel;
        w.nib     = nib;
        w.hold    = h;
        return w;
    endfunction

    always_comb begin
        unique case (i_addr)
            // power-up wait, all pins low
            5'd0:  o_uword = mk(1'b0, RS_ZERO, 1'b0, NS_CONST, 4'h0, H_20000);
            // wake nibbles
            5'd1:  o_uword = mk(1'b0, RS_ZERO, 1'b1, NS_CONST, 4'h3, H_1);
            5'd2:  o_uword = mk(1'b0, RS_ZERO, 1'b0, NS_CONST, 4'h3, H_5100);
            5'd3:  o_uword = mk(1'b0, RS_ZERO, 1'b1, NS_CONST, 4'h3, H_1);
            5'd4:  o_uword = mk(1'b0, RS_ZERO, 1'b0, NS_CONST, 4'h3, H_250);
            5'd5:  o_uword = mk(1'b0, RS_ZERO, 1'b1, NS_CONST, 4'h3, H_1);
            5'd6:  o_uword = mk(1'b0, RS_ZERO, 1'b0, NS_CONST, 4'h3, H_250);
            5'd7:  o_uword = mk(1'b0, RS_ZERO, 1'b1, NS_CONST, 4'h2, H_1);
            5'd8:  o_uword = mk(1'b0, RS_ZERO, 1'b0, NS_CONST, 4'h2, H_250);
            // function set 0x28
            5'd9:  o_uword = mk(1'b0, RS_ZERO, 1'b1, NS_CONST, 4'h2, H_1);
            5'd10: o_uword = mk(1'b0, RS_ZERO, 1'b0, NS_CONST, 4'h2, H_100);
            5'd11: o_uword = mk(1'b0, RS_ZERO, 1'b1, NS_CONST, 4'h8, H_1);
            5'd12: o_uword = mk(1'b0, RS_ZERO, 1'b0, NS_CONST, 4'h8, H_150);
            // display on 0x0c
            5'd13: o_uword = mk(1'b0, RS_ZERO, 1'b1, NS_CONST, 4'h0, H_1);
            5'd14: o_uword = mk(1'b0, RS_ZERO, 1'b0, NS_CONST, 4'h0, H_100);
            5'd15: o_uword = mk(1'b0, RS_ZERO, 1'b1, NS_CONST, 4'hC, H_1);
            5'd16: o_uword = mk(1'b0, RS_ZERO, 1'b0, NS_CONST, 4'hC, H_150);
            // clear 0x01
            5'd17: o_uword = mk(1'b0, RS_ZERO, 1'b1, NS_CONST, 4'h0, H_1);
            5'd18: o_uword = mk(1'b0, RS_ZERO, 1'b0, NS_CONST, 4'h0, H_100);
            5'd19: o_uword = mk(1'b0, RS_ZERO, 1'b1, NS_CONST, 4'h1, H_1);
            5'd20: o_uword = mk(1'b0, RS_ZERO, 1'b0, NS_CONST, 4'h1, H_2100);
            // entry mode 0x06 with extra settle time
            5'd21: o_uword = mk(1'b0, RS_ZERO, 1'b1, NS_CONST, 4'h0, H_1);
            5'd22: o_uword = mk(1'b0, RS_ZERO, 1'b0, NS_CONST, 4'h0, H_100);
            5'd23: o_uword = mk(1'b0, RS_ZERO, 1'b1, NS_CONST, 4'h6, H_1);
            5'd24: o_uword = mk(1'b1, RS_ZERO, 1'b0, NS_CONST, 4'h6, H_2150);
            // generic byte program
            5'd25: o_uword = mk(1'b0, RS_REG, 1'b1, NS_HI, 4'h0, H_1);
            5'd26: o_uword = mk(1'b0, RS_REG, 1'b0, NS_HI, 4'h0, H_100);
            5'd27: o_uword = mk(1'b0, RS_REG, 1'b1, NS_LO, 4'h0, H_1);
            5'd28: o_uword = mk(1'b1, RS_REG, 1'b0, NS_LO, 4'h0, H_TAIL);
            default: o_uword = mk(1'b1, RS_ZERO, 1'b0, NS_CONST, 4'h0, H_1);
        endcase
    end

endmodule

[hw/rtl/lcdns_datapath.sv]
// byte latch, goto address build and phase field formation
module lcdns_datapath (
    input  logic              i_clk,
    input  logic              i_load,
    input  lcdns_pkg::t_mode  i_mode,
    input  logic [7:0]        i_value,
    input  logic [2:0]        i_row,
    input  logic [5:0]        i_col,
    input  lcdns_pkg::t_uword i_uword,
    output lcdns_pkg::t_phase o_phase
);
    import lcdns_pkg::*;

    logic [7:0] r_byte, n_byte;
    logic       r_rs, n_rs;
    logic       r_long_tail, n_long_tail;
    logic [1:0] w_row;

    always_comb begin
        w_row = (i_row > ROW_MAX) ? ROW_MAX[1:0] : i_row[1:0];
        unique case (i_mode)
            MODE_GOTO: n_byte = CMD_DDRAM | (ROW_BASE[w_row] + {2'b00, i_col});
            MODE_INIT,
            MODE_CMD,
            MODE_DATA: n_byte = i_value;
            default:   n_byte = i_value;
        endcase
        n_rs        = (i_mode == MODE_DATA);
        n_long_tail = (i_mode != MODE_DATA)
                      && (n_byte == CMD_CLEAR || n_byte == CMD_HOME);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte      <= n_byte;
            r_rs        <= n_rs;
            r_long_tail <= n_long_tail;
        end
    end

    always_comb begin
        o_phase.rs = (i_uword.rs_sel == RS_REG) ? r_rs : 1'b0;
        o_phase.en = i_uword.en;
        unique case (i_uword.nib_sel)
            NS_HI:    o_phase.nibble = r_byte[7:4];
            NS_LO:    o_phase.nibble = r_byte[3:0];
            NS_CONST: o_phase.nibble = i_uword.nib;
            default:  o_phase.nibble = i_uword.nib;
        endcase
        o_phase.hold_us = hold_value(i_uword.hold, r_long_tail);
        o_phase.last    = i_uword.last;
    end

endmodule

[hw/rtl/char_lcd_nibble_sequencer_unit.sv]
// top level of the 4-bit character lcd pin phase sequencer
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  request | in        | i_in_valid / o_in_stall   | i_mode i_value i_row i_col
//  phase   | out       | o_out_valid / i_out_stall | o_rs o_en o_nibble o_hold_us o_last
//
// one request is taken at a time; the step counter walks the microcode
// table and one phase leaves per cycle while the output is not stalled
// a byte, command or goto request runs the 4-step byte program after its accept,
// init runs the 25-step init program after its accept; the step counter sets this pace
// reset clears the busy flag and the output valid; no clearing pass
// an output stall while the output is valid freezes the step counter and holds the phase register
module char_lcd_nibble_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_value,
    input  logic [2:0]  i_row,
    input  logic [5:0]  i_col,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_rs,
    output logic        o_en,
    output logic [3:0]  o_nibble,
    output logic [14:0] o_hold_us,
    output logic        o_last
);
    import lcdns_pkg::*;

    // sequencer state
    logic            r_busy, n_busy;
    logic [PC_W-1:0] r_pc, n_pc;
    logic            r_out_valid, n_out_valid;

    // output phase register, payload only
    t_phase r_phase;

    t_uword w_uword;
    t_phase w_phase;
    t_mode  w_mode;
    logic   w_accept;
    logic   w_step;

    assign w_mode   = t_mode'(i_mode);
    assign w_accept = i_in_valid && !r_busy;
    // a step runs while busy when the phase register is free or being drained
    assign w_step   = r_busy && (!r_out_valid || !i_out_stall);

    lcdns_ucode_rom u_rom (
        .i_addr  (r_pc),
        .o_uword (w_uword)
    );

    lcdns_datapath u_dp (
        .i_clk   (i_clk),
        .i_load  (w_accept),
        .i_mode  (w_mode),
        .i_value (i_value),
        .i_row   (i_row),
        .i_col   (i_col),
        .i_uword (w_uword),
        .o_phase (w_phase)
    );

    // next step: program entry on accept, increment per phase, stop on last
    always_comb begin
        n_busy      = r_busy;
        n_pc        = r_pc;
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_busy = 1'b1;
            n_pc   = (w_mode == MODE_INIT) ? INIT_ENTRY : BYTE_ENTRY;
        end else if (w_step) begin
            n_pc = r_pc + 1'b1;
            if (w_uword.last) begin
                n_busy = 1'b0;
            end
        end
        if (w_step) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= INIT_ENTRY;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_phase <= w_phase;
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_rs        = r_phase.rs;
    assign o_en        = r_phase.en;
    assign o_nibble    = r_phase.nibble;
    assign o_hold_us   = r_phase.hold_us;
    assign o_last      = r_phase.last;

endmodule
